// File: src/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg: shared codes of the first-fit block allocator
// operation codes and status codes carried on the item and result ports
// ----------------------------------------------------------------------------
package ffba_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_OOB       = 2'd3
  } status_e;

  // request byte count width, and the width of bytes plus metadata plus rounding
  localparam int unsigned ByteW = 16;
  localparam int unsigned DivW  = 17;

endpackage

// File: src/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap block allocator
// block table in a memory, one header read per cycle during the alloc walk
// ----------------------------------------------------------------------------
// usage
//   command channel: a word is taken at a clock edge with start high and busy
//   low; operation picks allocate, free or bounds check. busy stays high until
//   the result word has been issued; an unused op code does not raise busy.
//   result channel: done_o is high for exactly one cycle with status_o,
//   result_granule_o and result_length_o; the receiver cannot stall it and
//   must take the word in that cycle.
//   config: cfg_we_i writes the heap size (clipped to 1..NUM_GRANULES); this
//   rebuilds the table as one free block, which takes a clearing pass.
// steps after the accepting edge
//   allocate: reciprocal multiply for the granule count, then the walk over the
//   block headers (at most heap size of them), then a remainder block write when
//   one is split off; bound by the single memory read port, one header a cycle
//   free: entry read, successor read, merge writes
//   check: entry read; unused op code: answered straight from idle
// reset and heap writes start a clearing pass over all NUM_GRANULES entries,
// one table entry a cycle through the write port; busy is high meanwhile.
// one word in flight at a time; the next word is taken once the last result is out.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int unsigned NUM_GRANULES   = 1024,
  parameter int unsigned GRANULE_BYTES  = 40,
  parameter int unsigned METADATA_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [10:0]       cfg_wdata_i,
  // command word
  input  logic              start,
  output logic              busy,
  input  ffba_pkg::op_e     operation_i,
  input  logic [15:0]       request_bytes_i,
  input  logic [9:0]        block_granule_i,
  input  logic [15:0]       access_offset_i,
  input  logic [15:0]       access_length_i,
  // result word
  output logic              done_o,
  output ffba_pkg::status_e status_o,
  output logic [9:0]        result_granule_o,
  output logic [15:0]       result_length_o
);
  import ffba_pkg::*;

  // table index width and width of lengths and heap size (up to NUM_GRANULES)
  localparam int unsigned GW = $clog2(NUM_GRANULES);
  localparam int unsigned LW = $clog2(NUM_GRANULES + 1);
  // reciprocal of the granule size, exact floor quotient for any DivW-bit value
  localparam int unsigned RecipW   = DivW + 1;
  localparam int unsigned DivShift = DivW + $clog2(GRANULE_BYTES);
  localparam longint unsigned Recip =
      ((64'd1 << DivShift) + 64'(GRANULE_BYTES) - 64'd1) / 64'(GRANULE_BYTES);
  localparam int unsigned HeapReset = (NUM_GRANULES < 1024) ? NUM_GRANULES : 1024;
  localparam int unsigned RoundAdd  = METADATA_BYTES + GRANULE_BYTES - 1;

  // one table entry: block start, allocated, length in granules, payload bytes
  typedef struct packed {
    logic              start;
    logic              used;
    logic [LW-1:0]     len;
    logic [ByteW-1:0]  bytes;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_WALK,
    S_SPLIT,
    S_LOOKUP,
    S_FREE_NX,
    S_FREE_CLR
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [ByteW-1:0]  bytes_q, bytes_d;
  logic [9:0]        gran_q, gran_d;
  logic [ByteW-1:0]  off_q, off_d;
  logic [ByteW-1:0]  alen_q, alen_d;
  logic [LW-1:0]     heap_q, heap_d;
  logic [LW-1:0]     ptr_q, ptr_d;
  logic [DivW-1:0]   need_q, need_d;
  logic [LW-1:0]     len_q, len_d;
  logic [LW-1:0]     rest_q, rest_d;
  logic [GW-1:0]     nx_q, nx_d;
  logic [DivW-1:0]   div_q, div_d;
  logic [GW-1:0]     clr_q, clr_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [9:0]        rg_q, rg_d;
  logic [15:0]       rl_q, rl_d;

  // table memory, one write and one registered read port
  entry_t            mem [NUM_GRANULES];
  entry_t            rd_data_q;
  logic              mem_we;
  logic [GW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [GW-1:0]     mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  always_comb begin
    logic [DivW+RecipW-1:0] prod;
    logic [DivW-1:0] quot;
    logic [31:0]   step;
    logic [31:0]   nxt;
    logic          fit;
    int unsigned   hv;

    state_d   = state_q;
    op_d      = op_q;
    bytes_d   = bytes_q;
    gran_d    = gran_q;
    off_d     = off_q;
    alen_d    = alen_q;
    heap_d    = heap_q;
    ptr_d     = ptr_q;
    need_d    = need_q;
    len_d     = len_q;
    rest_d    = rest_q;
    nx_d      = nx_q;
    div_d     = div_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    status_d  = status_q;
    rg_d      = rg_q;
    rl_d      = rl_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;

    // granule count: multiply by the reciprocal, keep the high bits
    prod = (DivW+RecipW)'(div_q) * (DivW+RecipW)'(Recip);
    quot = DivW'(prod >> DivShift);

    // walk: the header at ptr_q is in rd_data_q
    step = rd_data_q.start ? 32'(rd_data_q.len) : 32'd1;
    if (step == 32'd0) begin
      step = 32'd1;
    end
    nxt = 32'(ptr_q) + step;
    fit = rd_data_q.start && !rd_data_q.used &&
          (32'(rd_data_q.len) >= 32'(need_q)) &&
          (32'(ptr_q) + 32'(rd_data_q.len) <= 32'(heap_q));
    hv  = 32'(cfg_wdata_i);

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == '0) begin
          mem_wdata = '{start: 1'b1, used: 1'b0, len: heap_q, bytes: '0};
        end
        if (clr_q == GW'(NUM_GRANULES - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        // free and check read their entry straight from the port
        mem_raddr = GW'(block_granule_i);
        if (start) begin
          op_d    = operation_i;
          bytes_d = request_bytes_i;
          gran_d  = block_granule_i;
          off_d   = access_offset_i;
          alen_d  = access_length_i;
          unique case (operation_i)
            OP_ALLOC: begin
              div_d   = DivW'(32'(request_bytes_i) + RoundAdd);
              state_d = S_DIV;
            end
            OP_FREE, OP_CHECK: begin
              state_d = S_LOOKUP;
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_OK;
              rg_d     = '0;
              rl_d     = '0;
            end
          endcase
        end
      end

      S_DIV: begin
        // granules needed, at least one; walk starts at granule 0
        need_d  = (quot == '0) ? DivW'(1) : quot;
        ptr_d   = '0;
        state_d = S_WALK;
      end

      S_WALK: begin
        if (fit) begin
          mem_we    = 1'b1;
          mem_waddr = GW'(ptr_q);
          mem_wdata = '{start: 1'b1, used: 1'b1, len: LW'(need_q), bytes: bytes_q};
          rest_d    = rd_data_q.len - LW'(need_q);
          if (rd_data_q.len != LW'(need_q)) begin
            state_d = S_SPLIT;
          end else begin
            state_d  = S_IDLE;
            done_d   = 1'b1;
            status_d = ST_OK;
            rg_d     = 10'(ptr_q);
            rl_d     = '0;
          end
        end else if (nxt >= 32'(heap_q)) begin
          // walked off the heap end
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = ST_NO_FIT;
          rg_d     = '0;
          rl_d     = '0;
        end else begin
          ptr_d     = LW'(nxt);
          mem_raddr = GW'(nxt);
        end
      end

      S_SPLIT: begin
        // remainder becomes a free block right after the granted one
        mem_we    = 1'b1;
        mem_waddr = GW'(32'(ptr_q) + 32'(need_q));
        mem_wdata = '{start: 1'b1, used: 1'b0, len: rest_q, bytes: '0};
        state_d   = S_IDLE;
        done_d    = 1'b1;
        status_d  = ST_OK;
        rg_d      = 10'(ptr_q);
        rl_d      = '0;
      end

      S_LOOKUP: begin
        rg_d = '0;
        rl_d = '0;
        if (!((32'(gran_q) < 32'(heap_q)) && rd_data_q.start && rd_data_q.used)) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = ST_NOT_ALLOC;
        end else if (op_q == OP_CHECK) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          if (32'(off_q) + 32'(alen_q) <= 32'(rd_data_q.bytes)) begin
            status_d = ST_OK;
            rl_d     = alen_q;
          end else begin
            status_d = ST_OOB;
          end
        end else begin
          len_d = rd_data_q.len;
          if (32'(gran_q) + 32'(rd_data_q.len) < 32'(heap_q)) begin
            nx_d      = GW'(32'(gran_q) + 32'(rd_data_q.len));
            mem_raddr = GW'(32'(gran_q) + 32'(rd_data_q.len));
            state_d   = S_FREE_NX;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = GW'(gran_q);
            mem_wdata = '{start: 1'b1, used: 1'b0, len: rd_data_q.len, bytes: '0};
            state_d   = S_IDLE;
            done_d    = 1'b1;
            status_d  = ST_OK;
          end
        end
      end

      S_FREE_NX: begin
        mem_we    = 1'b1;
        mem_waddr = GW'(gran_q);
        if (rd_data_q.start && !rd_data_q.used) begin
          // merge with the free successor, then drop its header
          mem_wdata = '{start: 1'b1, used: 1'b0, len: len_q + rd_data_q.len, bytes: '0};
          state_d   = S_FREE_CLR;
        end else begin
          mem_wdata = '{start: 1'b1, used: 1'b0, len: len_q, bytes: '0};
          state_d   = S_IDLE;
          done_d    = 1'b1;
          status_d  = ST_OK;
        end
      end

      S_FREE_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = nx_q;
        mem_wdata = '0;
        state_d   = S_IDLE;
        done_d    = 1'b1;
        status_d  = ST_OK;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // heap size write rebuilds the table
    if (cfg_we_i) begin
      if (hv < 1) begin
        hv = 1;
      end
      if (hv > NUM_GRANULES) begin
        hv = NUM_GRANULES;
      end
      heap_d  = LW'(hv);
      clr_d   = '0;
      state_d = S_CLEAR;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      heap_q   <= LW'(HeapReset);
      clr_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      rg_q     <= '0;
      rl_q     <= '0;
    end else begin
      state_q  <= state_d;
      heap_q   <= heap_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      status_q <= status_d;
      rg_q     <= rg_d;
      rl_q     <= rl_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    bytes_q <= bytes_d;
    gran_q  <= gran_d;
    off_q   <= off_d;
    alen_q  <= alen_d;
    ptr_q   <= ptr_d;
    need_q  <= need_d;
    len_q   <= len_d;
    rest_q  <= rest_d;
    nx_q    <= nx_d;
    div_q   <= div_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign result_granule_o = rg_q;
  assign result_length_o  = rl_q;

endmodule

// File: sim/first_fit_block_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_test: self-checking bench of the heap allocator
// sends allocate, free, check and unused op words through the start/busy port,
// keeps a heap table of its own to work out each reply word, and compares every
// done_o word field by field in order of issue
// ----------------------------------------------------------------------------
module first_fit_block_allocator_test;
  import ffba_pkg::*;

  localparam int unsigned NumGranules   = 1024;
  localparam int unsigned GranuleBytes  = 40;
  localparam int unsigned MetadataBytes = 16;

  typedef struct {
    status_e     status;
    logic [9:0]  granule;
    logic [15:0] granted_len;
  } heap_reply_t;

  // block ports, the inputs driven to known values from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [10:0] cfg_wdata_i     = '0;
  logic        start           = 1'b0;
  logic        busy;
  op_e         operation_i     = OP_ALLOC;
  logic [15:0] request_bytes_i = '0;
  logic [9:0]  block_granule_i = '0;
  logic [15:0] access_offset_i = '0;
  logic [15:0] access_length_i = '0;
  logic        done_o;
  status_e     status_o;
  logic [9:0]  result_granule_o;
  logic [15:0] result_length_o;

  // heap table as the block should hold it: one entry per granule
  bit          blk_start [NumGranules];
  bit          blk_used  [NumGranules];
  int unsigned blk_len   [NumGranules];
  int unsigned blk_bytes [NumGranules];
  int unsigned heap_limit;
  int unsigned walk_end;

  heap_reply_t pending_replies[$];
  logic [9:0]  live_blocks[$];     // start granules currently allocated

  int sender_idle_pct = 0;
  int errors          = 0;
  int words_sent      = 0;
  int replies_checked = 0;
  int grants          = 0;
  int refusals        = 0;
  int heap_writes     = 0;

  first_fit_block_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .request_bytes_i (request_bytes_i),
    .block_granule_i (block_granule_i),
    .access_offset_i (access_offset_i),
    .access_length_i (access_length_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .result_granule_o(result_granule_o),
    .result_length_o (result_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one free block over the whole heap, as after reset or a heap size write
  function automatic void rebuild_heap(input int unsigned granules);
    heap_limit = granules;
    for (int i = 0; i < NumGranules; i++) begin
      blk_start[i] = 1'b0;
      blk_used[i]  = 1'b0;
      blk_len[i]   = 0;
      blk_bytes[i] = 0;
    end
    blk_start[0] = 1'b1;
    blk_len[0]   = granules;
    walk_end     = 0;
  endfunction

  // carries one accepted word through the heap table and returns its reply
  function automatic heap_reply_t apply_word_to_heap(input op_e op, input logic [15:0] req,
      input logic [9:0] gran, input logic [15:0] off, input logic [15:0] alen);
    heap_reply_t reply;
    int unsigned need, p, rest, nx;
    bit          found;
    reply.status      = ST_OK;
    reply.granule     = '0;
    reply.granted_len = '0;
    found             = 1'b0;
    case (op)
      OP_ALLOC: begin
        // payload plus header, rounded up to whole granules
        need = (32'(req) + MetadataBytes + GranuleBytes - 1) / GranuleBytes;
        if (need == 0) need = 1;
        p = 0;
        while (p < heap_limit && !found) begin
          if (blk_start[p] && !blk_used[p] && blk_len[p] >= need &&
              p + blk_len[p] <= heap_limit) begin
            rest         = blk_len[p] - need;
            blk_used[p]  = 1'b1;
            blk_len[p]   = need;
            blk_bytes[p] = 32'(req);
            // exact fit leaves no remainder header
            if (rest != 0) begin
              blk_start[p + need] = 1'b1;
              blk_used[p + need]  = 1'b0;
              blk_len[p + need]   = rest;
              blk_bytes[p + need] = 0;
            end
            found = 1'b1;
          end else begin
            p += (blk_start[p] && blk_len[p] != 0) ? blk_len[p] : 1;
          end
        end
        walk_end = p;
        if (found) reply.granule = p[9:0];
        else reply.status = ST_NO_FIT;
      end
      OP_FREE, OP_CHECK: begin
        if (!(gran < heap_limit && blk_start[gran] && blk_used[gran])) begin
          reply.status = ST_NOT_ALLOC;
        end else if (op == OP_FREE) begin
          nx              = gran + blk_len[gran];
          blk_used[gran]  = 1'b0;
          blk_bytes[gran] = 0;
          // merge forward only
          if (nx < heap_limit && blk_start[nx] && !blk_used[nx]) begin
            blk_len[gran] += blk_len[nx];
            blk_start[nx] = 1'b0;
            blk_used[nx]  = 1'b0;
            blk_len[nx]   = 0;
            blk_bytes[nx] = 0;
          end
        end else if (32'(off) + 32'(alen) <= blk_bytes[gran]) begin
          reply.granted_len = alen;
        end else begin
          reply.status = ST_OOB;
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  // the result port cannot be held off: every done_o cycle carries a word
  heap_reply_t want;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      replies_checked++;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing pending: status %0d granule %0d length %0d",
                 $time, status_o, result_granule_o, result_length_o);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
        end
        if (result_granule_o !== want.granule) begin
          errors++;
          $display("%0t: granule expected %0d got %0d", $time, want.granule,
                   result_granule_o);
        end
        if (result_length_o !== want.granted_len) begin
          errors++;
          $display("%0t: length expected %0d got %0d", $time, want.granted_len,
                   result_length_o);
        end
      end
    end
  end

  // presents one command word and holds it until the block takes it; start
  // stays high on return so back-to-back words need no extra edge
  task automatic issue_word(input op_e op, input logic [15:0] req, input logic [9:0] gran,
                            input logic [15:0] off, input logic [15:0] alen);
    heap_reply_t reply;
    operation_i     <= op;
    request_bytes_i <= req;
    block_granule_i <= gran;
    access_offset_i <= off;
    access_length_i <= alen;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
    reply = apply_word_to_heap(op, req, gran, off, alen);
    pending_replies.push_back(reply);
    words_sent++;
    if (op == OP_ALLOC) begin
      if (reply.status == ST_OK) begin
        grants++;
        live_blocks.push_back(reply.granule);
      end else begin
        refusals++;
      end
    end
    if (op == OP_FREE && reply.status == ST_OK) begin
      for (int i = 0; i < live_blocks.size(); i++) begin
        if (live_blocks[i] == gran) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
    // random idle gaps land before, during and after the block's work
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  endtask

  // heap size is only written with the block idle and every reply in
  task automatic write_heap_size(input logic [10:0] value);
    int unsigned granules;
    start <= 1'b0;
    while (busy || pending_replies.size() != 0) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    granules = 32'(value);
    if (granules < 1) granules = 1;
    if (granules > NumGranules) granules = NumGranules;
    rebuild_heap(granules);
    live_blocks.delete();
    heap_writes++;
  endtask

  // rounding, exact fits, bounds edges, double free, forward merge only
  task automatic test_directed_words();
    issue_word(OP_ALLOC, 16'd0, '0, '0, '0);           // zero bytes still takes a granule
    issue_word(OP_ALLOC, 16'd24, '0, '0, '0);          // header plus payload fills one
    issue_word(OP_ALLOC, 16'd25, '0, '0, '0);          // one byte over: two granules
    issue_word(OP_CHECK, '0, 10'd2, 16'd0, 16'd25);    // whole payload
    issue_word(OP_CHECK, '0, 10'd2, 16'd25, 16'd0);    // empty access at payload end
    issue_word(OP_CHECK, '0, 10'd2, 16'd1, 16'd25);    // one byte past
    issue_word(OP_CHECK, '0, 10'd3, '0, '0);           // inside a block, not a start
    issue_word(OP_CHECK, 16'hffff, 10'h3ff, 16'hffff, 16'hffff);
    issue_word(OP_CHECK, '0, 10'd4, '0, '0);           // start of the free remainder
    issue_word(OP_FREE, '0, 10'd1, '0, '0);
    issue_word(OP_FREE, '0, 10'd1, '0, '0);            // double free
    issue_word(OP_ALLOC, 16'd0, '0, '0, '0);           // refills the hole exactly
    issue_word(OP_FREE, '0, 10'd2, '0, '0);            // merges with free successor
    issue_word(OP_ALLOC, 16'hffff, '0, '0, '0);        // larger than any heap
    issue_word(OP_ALLOC, 16'd40864, '0, '0, '0);       // exactly the rest of the heap
    issue_word(OP_CHECK, '0, 10'd2, 16'hffff, 16'hffff);
    issue_word(OP_CHECK, '0, 10'd2, 16'd40000, 16'd864);
    issue_word(OP_ALLOC, 16'd0, '0, '0, '0);           // heap full, walk ends at heap end
    issue_word(OP_NOP, 16'hffff, 10'h3ff, 16'hffff, 16'hffff);
    issue_word(OP_FREE, '0, 10'd0, '0, '0);
    issue_word(OP_FREE, '0, 10'd1, '0, '0);
    issue_word(OP_FREE, '0, 10'd2, '0, '0);
    issue_word(OP_ALLOC, 16'd60, '0, '0, '0);          // skips the two one-granule holes
  endtask

  // smallest heap, oversize write clipped to the full table, two-granule heap
  task automatic test_heap_size_extremes();
    write_heap_size(11'd0);
    issue_word(OP_ALLOC, 16'd0, '0, '0, '0);
    issue_word(OP_ALLOC, 16'd0, '0, '0, '0);
    issue_word(OP_FREE, '0, 10'd1, '0, '0);            // beyond the heap
    issue_word(OP_FREE, '0, 10'd0, '0, '0);
    write_heap_size(11'h7ff);
    issue_word(OP_ALLOC, 16'd40944, '0, '0, '0);       // whole heap in one block
    issue_word(OP_ALLOC, 16'd0, '0, '0, '0);
    issue_word(OP_FREE, '0, 10'd0, '0, '0);
    write_heap_size(11'd2);
    issue_word(OP_ALLOC, 16'd0, '0, '0, '0);
    issue_word(OP_ALLOC, 16'd0, '0, '0, '0);
    issue_word(OP_FREE, '0, 10'd0, '0, '0);
    issue_word(OP_FREE, '0, 10'd1, '0, '0);
    issue_word(OP_ALLOC, 16'd60, '0, '0, '0);          // two holes, never merged backward
  endtask

  // mostly small allocations so heaps fill, fragment and refuse; frees and
  // checks aim at live blocks, with checks clustered around the payload end
  task automatic random_word();
    int unsigned sel, req, pay, off, alen;
    int          span;
    logic [9:0]  gran;
    op_e         op;
    sel  = $urandom_range(99);
    req  = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(200);
    gran = $urandom_range(1) ? 10'($urandom_range(1023)) : 10'($urandom_range(heap_limit));
    off  = $urandom_range(65535);
    alen = $urandom_range(65535);
    if (sel >= 45 && sel < 95 && live_blocks.size() != 0 && $urandom_range(9) != 0)
      gran = live_blocks[$urandom_range(live_blocks.size() - 1)];
    if (sel >= 70 && sel < 95 && $urandom_range(7) != 0) begin
      pay  = blk_bytes[gran];
      off  = $urandom_range(pay);
      span = int'(pay - off) + 2 - int'($urandom_range(4));
      alen = (span < 0) ? 0 : span;
    end
    if (sel < 45) op = OP_ALLOC;
    else if (sel < 70) op = OP_FREE;
    else if (sel < 95) op = OP_CHECK;
    else op = OP_NOP;
    issue_word(op, 16'(req), gran, 16'(off), 16'(alen));
  endtask

  // three heap sizes per pass: small, tiny, and from 49 granules up to the full table
  task automatic test_random_traffic();
    write_heap_size(11'($urandom_range(8, 48)));
    repeat (60) random_word();
    write_heap_size(11'($urandom_range(1, 7)));
    repeat (60) random_word();
    write_heap_size(11'($urandom_range(49, 1024)));
    repeat (60) random_word();
  endtask

  initial begin
    int drain_wait;
    rebuild_heap(NumGranules);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_words();
    test_heap_size_extremes();
    sender_idle_pct = 24;
    test_random_traffic();
    sender_idle_pct = 68;
    test_random_traffic();
    sender_idle_pct = 0;
    test_random_traffic();

    // drain, then leave room for any stray extra word
    start      <= 1'b0;
    drain_wait = 0;
    while (pending_replies.size() != 0 && drain_wait < 20000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (50) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      errors++;
      $display("%0t: %0d result words never arrived", $time, pending_replies.size());
    end

    $display("%0d command words over %0d heap size writes, %0d result words checked",
             words_sent, heap_writes, replies_checked);
    $display("allocations granted %0d, refused %0d, mismatching fields %0d",
             grants, refusals, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // worst case is every word walking a full table; this is several times that
  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
